@@ rtl/core/dupf_pkg.sv @@
`default_nettype none
package dupf_pkg;

   // operation codes
   localparam logic [1:0] FUNC_ADD    = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_LOOKUP = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] header_crc;
      logic [31:0] msgid_crc;
   } req_type;

   typedef struct packed {
      logic       is_duplicate;
      logic [1:0] status;
   } rsp_type;

   // one table entry: flags and both keys in one memory word
   typedef struct packed {
      logic        valid;
      logic        header_live;
      logic        msgid_live;
      logic [31:0] header;
      logic [31:0] msgid;
   } entry_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_PURGE
   } state_type;

endpackage
`default_nettype wire

@@ rtl/core/two_key_duplicate_filter_table.sv @@
// channel | ports                        | transfer when
// --------+------------------------------+-------------------------------
// request | start, busy, req_item        | rising edge with start && !busy
// result  | rsp_valid, rsp_item          | rising edge ending a cycle with rsp_valid
//
// every add, remove or lookup is a scan of the entry memory, one entry per
// cycle over a single read port with a registered read
// add stops at the first free slot and lookup at the first duplicate hit
// remove scans for the exact pair, then runs a second read-modify-write pass
// over all entries to free its slot and clear live marks of matching keys
// reset starts a clearing pass over all entries with busy high
// the result strobe lasts one cycle and the receiver cannot hold it off
`default_nettype none
module two_key_duplicate_filter_table #(
   parameter int DEPTH = 64
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  dupf_pkg::req_type     req_item,
   output logic                  rsp_valid,
   output dupf_pkg::rsp_type     rsp_item
);
   import dupf_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

   // entry store, whole entries cleared to zero by the pass after reset
   entry_type entry_mem [DEPTH];

   state_type     state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;        // read issue index
   logic          issue_ff, issue_in;    // reads still to issue in this pass
   logic          q_vld_ff;              // read data valid this cycle
   logic [AW-1:0] q_addr_ff;
   entry_type     q_data_ff;
   req_type       req_ff, req_in;
   logic [AW-1:0] hit_ff, hit_in;        // slot of the pair being removed
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          rd_en;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   logic          finish;
   logic          hdr_eq, mid_eq, q_last, dup_hit, idx_last;
   entry_type     add_data, purge_data;

   // compares against the entry coming out of the memory
   assign hdr_eq   = (q_data_ff.header == req_ff.header_crc);
   assign mid_eq   = (q_data_ff.msgid == req_ff.msgid_crc);
   assign q_last   = (q_addr_ff == LAST_IDX);
   assign idx_last = (idx_ff == LAST_IDX);
   assign dup_hit  = q_data_ff.valid &&
                     (((req_ff.header_crc != 32'd0) && q_data_ff.header_live && hdr_eq) ||
                      ((req_ff.msgid_crc != 32'd0) && q_data_ff.msgid_live && mid_eq));

   // new entry: zero keys are stored but never live
   always_comb begin
      add_data.valid       = 1'b1;
      add_data.header_live = (req_ff.header_crc != 32'd0);
      add_data.msgid_live  = (req_ff.msgid_crc != 32'd0);
      add_data.header      = req_ff.header_crc;
      add_data.msgid       = req_ff.msgid_crc;
   end

   // purge pass: free the removed slot, drop live marks of matching keys
   always_comb begin
      purge_data = q_data_ff;
      if (q_addr_ff == hit_ff) begin
         purge_data.valid       = 1'b0;
         purge_data.header_live = 1'b0;
         purge_data.msgid_live  = 1'b0;
      end else if (q_data_ff.valid) begin
         if (hdr_eq) begin
            purge_data.header_live = 1'b0;
         end
         if (mid_eq) begin
            purge_data.msgid_live = 1'b0;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      issue_in     = issue_ff;
      req_in       = req_ff;
      hit_in       = hit_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = q_addr_ff;
      wr_data      = q_data_ff;
      finish       = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            // one entry per cycle after reset
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = '0;
            idx_in  = idx_ff + 1'b1;
            if (idx_last) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (start) begin
               req_in   = req_item;
               idx_in   = '0;
               issue_in = 1'b1;
               case (req_item.func)
                  FUNC_ADD, FUNC_REMOVE, FUNC_LOOKUP: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                     // unused code: answer at once, nothing changes
                     issue_in     = 1'b0;
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (q_vld_ff) begin
               case (req_ff.func)
                  FUNC_ADD: begin
                     if (!q_data_ff.valid) begin
                        wr_en   = 1'b1;
                        wr_data = add_data;
                        finish  = 1'b1;
                        rsp_in  = '{is_duplicate: 1'b0, status: STATUS_DONE};
                     end else if (q_last) begin
                        finish = 1'b1;
                        rsp_in = '{is_duplicate: 1'b0, status: STATUS_FULL};
                     end
                  end
                  FUNC_REMOVE: begin
                     if (q_data_ff.valid && hdr_eq && mid_eq) begin
                        // exact pair found: restart the scan as a purge pass
                        hit_in   = q_addr_ff;
                        state_in = ST_PURGE;
                        idx_in   = '0;
                        issue_in = 1'b1;
                     end else if (q_last) begin
                        finish = 1'b1;
                        rsp_in = '{is_duplicate: 1'b0, status: STATUS_NOT_FOUND};
                     end
                  end
                  FUNC_LOOKUP: begin
                     if (dup_hit) begin
                        finish = 1'b1;
                        rsp_in = '{is_duplicate: 1'b1, status: STATUS_DONE};
                     end else if (q_last) begin
                        finish = 1'b1;
                        rsp_in = '{is_duplicate: 1'b0, status: STATUS_DONE};
                     end
                  end
                  default: begin
                     finish = 1'b1;
                     rsp_in = '0;
                  end
               endcase
            end
            // keep issuing reads unless this pass just ended
            if (issue_ff && !finish && (state_in == ST_SCAN)) begin
               rd_en  = 1'b1;
               idx_in = idx_ff + 1'b1;
               if (idx_last) begin
                  issue_in = 1'b0;
               end
            end
         end

         ST_PURGE: begin
            if (q_vld_ff) begin
               wr_en   = 1'b1;
               wr_data = purge_data;
               if (q_last) begin
                  finish = 1'b1;
                  rsp_in = '{is_duplicate: 1'b0, status: STATUS_DONE};
               end
            end
            // next read goes to a later slot than the write-back, no hazard
            if (issue_ff) begin
               rd_en  = 1'b1;
               idx_in = idx_ff + 1'b1;
               if (idx_last) begin
                  issue_in = 1'b0;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         rsp_valid_in = 1'b1;
         state_in     = ST_IDLE;
         issue_in     = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         issue_ff     <= 1'b0;
         q_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         issue_ff     <= issue_in;
         q_vld_ff     <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      hit_ff    <= hit_in;
      rsp_ff    <= rsp_in;
      q_addr_ff <= idx_ff;
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_data_ff <= entry_mem[idx_ff];
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
`default_nettype wire

@@ rtl/core/dupf_checker.sv @@
`default_nettype none
module dupf_props (
   input wire               clock,
   input wire               reset,
   input wire               start,
   input wire               busy,
   input dupf_pkg::req_type req_item,
   input wire               rsp_valid,
   input dupf_pkg::rsp_type rsp_item
);
   import dupf_pkg::*;

   // a result only comes out once the operation is over
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && busy))
      else $error("result strobe while busy");

   // an accepted transfer either starts a scan or answers next cycle
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither started nor answered");

   // duplicate flag only with a done status
   a_dup_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.is_duplicate) |-> (rsp_item.status == STATUS_DONE))
      else $error("duplicate flag with error status");

   // unused operation code answers right away with all zero
   a_unused_func: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.func != FUNC_ADD) && (req_item.func != FUNC_REMOVE)
       && (req_item.func != FUNC_LOOKUP))
      |=> (rsp_valid && !rsp_item.is_duplicate && (rsp_item.status == STATUS_DONE)))
      else $error("unused code not answered with zero result");

endmodule

bind two_key_duplicate_filter_table dupf_props u_dupf_props (.*);
`default_nettype wire
